>>> rtl/core/rrss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrss_pkg: shared types and codes of the round-robin slice scheduler
// Transaction formats, status and request codes, and the entry format held
// in each cell of the task ring.
// ----------------------------------------------------------------------------
package rrss_pkg;

   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_STEP  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
   localparam logic [1:0] STATUS_GRANTED  = 2'd1;
   localparam logic [1:0] STATUS_FINISHED = 2'd2;
   localparam logic [1:0] STATUS_REJECTED = 2'd3;

   localparam int TIME_WIDTH = 24;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] arrival_time;
      logic [15:0] burst_time;
   } request_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [TIME_WIDTH-1:0] slice_start;
      logic [TIME_WIDTH-1:0] slice_end;
      logic [5:0]            task_id;
      logic [15:0]           ran;
      logic [15:0]           left;
   } response_type;

   // One task as held in a cell of the ring.
   typedef struct packed {
      logic [15:0] arrival;
      logic [15:0] remaining;
   } entry_type;

   // Control from the sequencer to the ring.
   typedef struct packed {
      logic      shift;
      entry_type tail;
   } ring_ctl_type;

endpackage

>>> rtl/core/rrss_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrss_cell: one cell of the task ring
// Holds a single task entry and takes its neighbour's entry on a shift.
// ----------------------------------------------------------------------------
module rrss_cell (
   input  logic                clock,
   input  logic                shift,
   input  rrss_pkg::entry_type din,
   output rrss_pkg::entry_type dout
);

   rrss_pkg::entry_type entry_ff;
   rrss_pkg::entry_type entry_in;

   always_comb begin
      entry_in = shift ? din : entry_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign dout = entry_ff;

endmodule

>>> rtl/core/rrss_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrss_ring: circular chain of task cells
// On a shift every cell takes the entry of the next one; the head cell's
// entry, possibly updated by the sequencer, re-enters at the tail.
// ----------------------------------------------------------------------------
module rrss_ring #(
   parameter int DEPTH = 64
) (
   input  logic                   clock,
   input  rrss_pkg::ring_ctl_type ctl,
   output rrss_pkg::entry_type    head
);

   rrss_pkg::entry_type cell_q [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      rrss_pkg::entry_type cell_d;
      if (i == DEPTH - 1) begin : g_tail
         assign cell_d = ctl.tail;
      end else begin : g_link
         assign cell_d = cell_q[i+1];
      end
      rrss_cell u_cell (
         .clock (clock),
         .shift (ctl.shift),
         .din   (cell_d),
         .dout  (cell_q[i])
      );
   end

   assign head = cell_q[0];

endmodule

>>> rtl/core/round_robin_slice_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_slice_scheduler: round-robin time-slice scheduler
// Keeps up to MAX_TASKS tasks in a rotating ring of cells and grants one
// time slice per step transaction in circular order.
// ----------------------------------------------------------------------------
// Usage. A request transaction is taken when start is high and busy is low;
// req_payload carries the request kind and, for a load, the task's arrival
// and burst times. Every request produces exactly one response transaction:
// rsp_valid is high for a single cycle with rsp_payload beside it. The
// receiver cannot stall, so a response is simply presented and gone.
// The quantum is written through csr_we/csr_wdata; the user must do so
// only while the block is idle, which the block itself does not enforce.
// Timing. A clear, a reserved request, a rejected load and a step with no
// unfinished task respond in the cycle after acceptance. Otherwise the
// task table is a ring that rotates one cell per cycle past a single head
// cell while a request is in progress: a load rotates by the distance
// (below MAX_TASKS) to its slot; a step by the distance to the scan start
// (usually zero), then examines at most MAX_TASKS cells, or 2 * MAX_TASKS
// if time must jump to the earliest arrival; busy is high until the response.
// Reset. A synchronous reset empties the table, sets time and the scan
// start to zero and the quantum to 4; ring contents need no clearing.
// ----------------------------------------------------------------------------
module round_robin_slice_scheduler #(
   parameter int MAX_TASKS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  rrss_pkg::request_type  req_payload,
   output logic                   rsp_valid,
   output rrss_pkg::response_type rsp_payload,
   input  logic                   csr_we,
   input  logic [15:0]            csr_wdata
);

   localparam int IW = $clog2(MAX_TASKS);
   localparam int CW = $clog2(MAX_TASKS + 1);
   localparam int TW = rrss_pkg::TIME_WIDTH;
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TASKS - 1);

   // Sequencer states: waiting, rotating the ring to a target slot, and
   // scanning the ring for a ready task.
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SEEK = 3'b010,
      ST_SCAN = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [IW-1:0]         rot_ff, rot_in;        // index of the task at the head
   logic [CW-1:0]         tc_ff, tc_in;          // task count
   logic [CW-1:0]         fin_ff, fin_in;        // finished task count
   logic [TW-1:0]         now_ff, now_in;
   logic [IW-1:0]         scan_ff, scan_in;      // where the next scan begins
   logic [15:0]           quantum_ff, quantum_in;
   logic [IW-1:0]         target_ff, target_in;
   logic                  is_load_ff, is_load_in;
   logic [IW-1:0]         cnt_ff, cnt_in;
   logic                  second_ff, second_in;
   logic [15:0]           earliest_ff, earliest_in;
   rrss_pkg::entry_type   pending_ff, pending_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rrss_pkg::response_type rsp_ff, rsp_in;

   rrss_pkg::ring_ctl_type ring_ctl;
   rrss_pkg::entry_type    head;

   rrss_ring #(
      .DEPTH (MAX_TASKS)
   ) u_ring (
      .clock (clock),
      .ctl   (ring_ctl),
      .head  (head)
   );

   // Head evaluation and slice arithmetic.
   logic [IW-1:0]   rot_next;
   logic [CW-1:0]   rot_plus;
   logic            head_live;
   logic            head_ready;
   logic [15:0]     q_eff;
   logic [15:0]     ran;
   logic [15:0]     left;
   logic [TW:0]     end_sum;
   logic [TW-1:0]   slice_end;
   logic [15:0]     earliest_cand;
   logic [IW+5:0]   id_wide;
   logic            table_full;

   always_comb begin
      rot_next      = (rot_ff == LAST_IDX) ? '0 : rot_ff + 1'b1;
      rot_plus      = CW'(rot_ff) + 1'b1;
      head_live     = (CW'(rot_ff) < tc_ff) && (head.remaining != 16'd0);
      head_ready    = head_live && ({8'd0, head.arrival} <= now_ff);
      q_eff         = (quantum_ff == 16'd0) ? 16'd1 : quantum_ff;
      ran           = (q_eff < head.remaining) ? q_eff : head.remaining;
      left          = head.remaining - ran;
      end_sum       = {1'b0, now_ff} + (TW+1)'(ran);
      slice_end     = end_sum[TW] ? '1 : end_sum[TW-1:0];
      earliest_cand = (head_live && (head.arrival < earliest_ff)) ?
                      head.arrival : earliest_ff;
      id_wide       = {6'd0, rot_ff};
      table_full    = (tc_ff >= CW'(MAX_TASKS));
   end

   always_comb begin
      state_in       = state_ff;
      rot_in         = rot_ff;
      tc_in          = tc_ff;
      fin_in         = fin_ff;
      now_in         = now_ff;
      scan_in        = scan_ff;
      quantum_in     = csr_we ? csr_wdata : quantum_ff;
      target_in      = target_ff;
      is_load_in     = is_load_ff;
      cnt_in         = cnt_ff;
      second_in      = second_ff;
      earliest_in    = earliest_ff;
      pending_in     = pending_ff;
      rsp_valid_in   = 1'b0;
      rsp_in         = rsp_ff;
      ring_ctl.shift = 1'b0;
      ring_ctl.tail  = head;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_in = '0;
               case (req_payload.req_type)
                  rrss_pkg::REQ_LOAD: begin
                     if (req_payload.burst_time == 16'd0 || table_full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = rrss_pkg::STATUS_REJECTED;
                     end else begin
                        pending_in.arrival   = req_payload.arrival_time;
                        pending_in.remaining = req_payload.burst_time;
                        target_in            = tc_ff[IW-1:0];
                        is_load_in           = 1'b1;
                        state_in             = ST_SEEK;
                     end
                  end
                  rrss_pkg::REQ_STEP: begin
                     if (tc_ff == '0 || fin_ff >= tc_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = rrss_pkg::STATUS_FINISHED;
                     end else begin
                        target_in  = scan_ff;
                        is_load_in = 1'b0;
                        state_in   = ST_SEEK;
                     end
                  end
                  rrss_pkg::REQ_CLEAR: begin
                     tc_in         = '0;
                     fin_in        = '0;
                     now_in        = '0;
                     scan_in       = '0;
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = rrss_pkg::STATUS_ACCEPTED;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = rrss_pkg::STATUS_ACCEPTED;
                  end
               endcase
            end
         end

         ST_SEEK: begin
            if (rot_ff == target_ff) begin
               if (is_load_ff) begin
                  // The new task replaces the head as the ring moves on.
                  ring_ctl.shift = 1'b1;
                  ring_ctl.tail  = pending_ff;
                  rot_in         = rot_next;
                  tc_in          = tc_ff + 1'b1;
                  rsp_valid_in   = 1'b1;
                  rsp_in         = '0;
                  rsp_in.status  = rrss_pkg::STATUS_ACCEPTED;
                  state_in       = ST_IDLE;
               end else begin
                  cnt_in      = '0;
                  second_in   = 1'b0;
                  earliest_in = '1;
                  state_in    = ST_SCAN;
               end
            end else begin
               ring_ctl.shift = 1'b1;
               rot_in         = rot_next;
            end
         end

         ST_SCAN: begin
            ring_ctl.shift = 1'b1;
            rot_in         = rot_next;
            if (head_ready) begin
               ring_ctl.tail.arrival   = head.arrival;
               ring_ctl.tail.remaining = left;
               now_in             = slice_end;
               scan_in            = (rot_plus == tc_ff) ? '0 : rot_plus[IW-1:0];
               if (left == 16'd0) begin
                  fin_in = fin_ff + 1'b1;
               end
               rsp_valid_in       = 1'b1;
               rsp_in.status      = rrss_pkg::STATUS_GRANTED;
               rsp_in.slice_start = now_ff;
               rsp_in.slice_end   = slice_end;
               rsp_in.task_id     = id_wide[5:0];
               rsp_in.ran         = ran;
               rsp_in.left        = left;
               state_in           = ST_IDLE;
            end else begin
               earliest_in = earliest_cand;
               if (cnt_ff == LAST_IDX) begin
                  // A full turn brings the head back to the scan start.
                  cnt_in = '0;
                  if (!second_ff) begin
                     second_in = 1'b1;
                     now_in    = {8'd0, earliest_cand};
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_in        = '0;
                     rsp_in.status = rrss_pkg::STATUS_FINISHED;
                     state_in      = ST_IDLE;
                  end
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rot_ff       <= '0;
         tc_ff        <= '0;
         fin_ff       <= '0;
         now_ff       <= '0;
         scan_ff      <= '0;
         quantum_ff   <= 16'd4;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rot_ff       <= rot_in;
         tc_ff        <= tc_in;
         fin_ff       <= fin_in;
         now_ff       <= now_in;
         scan_ff      <= scan_in;
         quantum_ff   <= quantum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff   <= target_in;
      is_load_ff  <= is_load_in;
      cnt_ff      <= cnt_in;
      second_ff   <= second_in;
      earliest_ff <= earliest_in;
      pending_ff  <= pending_in;
      rsp_ff      <= rsp_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   // Finished tasks are always a subset of the loaded ones.
   a_fin_bound: assert property (@(posedge clock) disable iff (reset)
      fin_ff <= tc_ff)
      else $error("finished count exceeds task count");

   // A granted slice is never empty and never runs backwards in time.
   a_grant_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == rrss_pkg::STATUS_GRANTED) |->
      (rsp_payload.ran != 16'd0 && rsp_payload.slice_end >= rsp_payload.slice_start))
      else $error("malformed slice grant");

   // A clear answers in the next cycle and leaves an empty table.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.req_type == rrss_pkg::REQ_CLEAR) |=>
      (rsp_valid && rsp_payload.status == rrss_pkg::STATUS_ACCEPTED &&
       tc_ff == '0 && now_ff == '0))
      else $error("clear did not empty the table");
`endif

endmodule

>>> tb/round_robin_slice_scheduler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_slice_scheduler_tb: self-checking bench for the slice scheduler
// Feeds load, step, clear and reserved request transactions with random gaps.
// A scheduler model in the bench predicts every response, and the bench checks
// each response field by field against it. The quantum is rewritten between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module round_robin_slice_scheduler_tb;

   localparam int          TABLE_DEPTH   = 64;
   localparam int          TARGET_ITEMS  = 450;
   // No transaction on either side for this many cycles means the block hangs.
   // The slowest step rotates to its scan start and then scans the ring twice,
   // and the longest sender gap comes on top of that.
   localparam int          STALL_LIMIT   = 2000;
   localparam int          DRAIN_CYCLES  = 250;
   localparam logic [1:0]  REQ_RESERVED  = 2'd3;
   localparam logic [23:0] TIME_CEILING  = 24'hFFFFFF;

   // One entry of the stimulus list: either a request transaction or a write
   // of the quantum register.
   typedef struct {
      bit                    is_cfg;
      rrss_pkg::request_type req;
      logic [15:0]           cfg_value;
   } stimulus_entry_type;

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   start       = 1'b0;
   rrss_pkg::request_type  req_payload = '0;
   logic                   csr_we      = 1'b0;
   logic [15:0]            csr_wdata   = '0;
   logic                   busy;
   logic                   rsp_valid;
   rrss_pkg::response_type rsp_payload;

   stimulus_entry_type     pending_stimulus[$];
   rrss_pkg::response_type awaited_responses[$];
   int                     failures = 0;

   // Scheduler state as the bench believes it to be.
   logic [15:0]   arrival_of[TABLE_DEPTH];
   logic [15:0]   remaining_of[TABLE_DEPTH];
   int unsigned   loaded_tasks   = 0;
   int unsigned   finished_tasks = 0;
   int unsigned   clock_now      = 0;
   int unsigned   next_scan      = 0;
   logic [15:0]   quantum_setting = 16'd4;

   round_robin_slice_scheduler #(
      .MAX_TASKS(TABLE_DEPTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Scheduler model
   // ------------------------------------------------------------------------

   // Circular search from the scan start for a task that has arrived and still
   // needs time. Returns -1 when no task is ready.
   function automatic int find_ready_slot();
      int unsigned p;
      for (int unsigned t = 0; t < loaded_tasks; t++) begin
         p = (next_scan + t) % loaded_tasks;
         if (arrival_of[p] <= clock_now && remaining_of[p] != 16'd0)
            return p;
      end
      return -1;
   endfunction

   // Applies one request transaction to the model and returns the response
   // that the block must give for it.
   function automatic rrss_pkg::response_type schedule_request(rrss_pkg::request_type r);
      rrss_pkg::response_type rsp;
      int           slot;
      int unsigned  earliest;
      int unsigned  q;
      int unsigned  ran;
      int unsigned  finish_at;
      logic [15:0]  rem;
      rsp = '0;
      rsp.status = rrss_pkg::STATUS_ACCEPTED;
      case (r.req_type)
         rrss_pkg::REQ_LOAD: begin
            if (r.burst_time == 16'd0 || loaded_tasks >= TABLE_DEPTH) begin
               rsp.status = rrss_pkg::STATUS_REJECTED;
            end else begin
               arrival_of[loaded_tasks]   = r.arrival_time;
               remaining_of[loaded_tasks] = r.burst_time;
               loaded_tasks++;
            end
         end
         rrss_pkg::REQ_CLEAR: begin
            loaded_tasks   = 0;
            finished_tasks = 0;
            clock_now      = 0;
            next_scan      = 0;
         end
         rrss_pkg::REQ_STEP: begin
            if (loaded_tasks == 0 || finished_tasks >= loaded_tasks) begin
               rsp.status = rrss_pkg::STATUS_FINISHED;
               return rsp;
            end
            slot = find_ready_slot();
            if (slot < 0) begin
               // Nothing is ready, so time leaps to the earliest arrival among
               // the unfinished tasks.
               earliest = 32'hFFFF_FFFF;
               for (int unsigned i = 0; i < loaded_tasks; i++) begin
                  if (remaining_of[i] != 16'd0 && arrival_of[i] < earliest)
                     earliest = 32'(arrival_of[i]);
               end
               clock_now = earliest;
               slot = find_ready_slot();
               if (slot < 0) begin
                  rsp.status = rrss_pkg::STATUS_FINISHED;
                  return rsp;
               end
            end
            q         = (quantum_setting == 16'd0) ? 32'd1 : 32'(quantum_setting);
            rem       = remaining_of[slot];
            ran       = (q < 32'(rem)) ? q : 32'(rem);
            finish_at = clock_now + ran;
            if (finish_at > 32'(TIME_CEILING))
               finish_at = 32'(TIME_CEILING);
            remaining_of[slot] = rem - ran[15:0];
            if (rem == ran)
               finished_tasks++;
            rsp.status      = rrss_pkg::STATUS_GRANTED;
            rsp.slice_start = clock_now[23:0];
            rsp.slice_end   = finish_at[23:0];
            rsp.task_id     = slot[5:0];
            rsp.ran         = ran[15:0];
            rsp.left        = rem - ran[15:0];
            clock_now       = finish_at;
            next_scan       = (slot + 1) % loaded_tasks;
         end
         default: begin
            // A reserved request kind is ignored and simply acknowledged.
         end
      endcase
      return rsp;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   int request_total = 0;

   task automatic add_request(input logic [1:0] kind, input logic [15:0] arrival,
                              input logic [15:0] burst);
      stimulus_entry_type e;
      e.is_cfg           = 1'b0;
      e.req.req_type     = kind;
      e.req.arrival_time = arrival;
      e.req.burst_time   = burst;
      e.cfg_value        = '0;
      pending_stimulus.push_back(e);
      if (kind != REQ_RESERVED)
         request_total++;
   endtask

   task automatic add_quantum_write(input logic [15:0] value);
      stimulus_entry_type e;
      e.is_cfg    = 1'b1;
      e.req       = '0;
      e.cfg_value = value;
      pending_stimulus.push_back(e);
   endtask

   // Mostly early arrivals so that tasks compete, with some across the whole
   // 16-bit range to force the jump to the earliest arrival.
   function automatic logic [15:0] pick_arrival();
      if ($urandom_range(0, 9) < 7)
         return 16'($urandom_range(0, 40));
      return 16'($urandom_range(0, 65535));
   endfunction

   // Mostly short bursts so that tasks run to completion within a phase.
   function automatic logic [15:0] pick_burst();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 75)
         return 16'($urandom_range(1, 12));
      if (roll < 95)
         return 16'($urandom_range(1, 65535));
      return 16'hFFFF;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus list and end of run
   // ------------------------------------------------------------------------

   initial begin : stimulus
      int          n_load;
      int          n_step;
      int          roll;
      int          full_phases;
      logic [15:0] q;
      full_phases = 0;

      // Directed opening: empty table, reserved kind, rejected load, extreme
      // field values, a late load that is ready at once, quantum of zero and
      // of its largest value, and the step after every task has finished.
      add_request(rrss_pkg::REQ_STEP, 16'h0000, 16'h0000);
      add_request(REQ_RESERVED, 16'hFFFF, 16'hFFFF);
      add_request(rrss_pkg::REQ_CLEAR, 16'hFFFF, 16'hFFFF);
      add_request(rrss_pkg::REQ_LOAD, 16'h1234, 16'h0000);
      add_request(rrss_pkg::REQ_LOAD, 16'hFFFF, 16'hFFFF);
      add_request(rrss_pkg::REQ_LOAD, 16'h0000, 16'h0001);
      add_request(rrss_pkg::REQ_LOAD, 16'h0003, 16'h0009);
      repeat (4) add_request(rrss_pkg::REQ_STEP, 16'h0000, 16'h0000);
      add_request(rrss_pkg::REQ_LOAD, 16'h0000, 16'h0002);
      repeat (3) add_request(rrss_pkg::REQ_STEP, 16'hFFFF, 16'hFFFF);
      add_quantum_write(16'h0000);
      repeat (2) add_request(rrss_pkg::REQ_STEP, 16'h0000, 16'h0000);
      add_quantum_write(16'hFFFF);
      repeat (3) add_request(rrss_pkg::REQ_STEP, 16'h0000, 16'h0000);
      add_request(rrss_pkg::REQ_CLEAR, 16'h0000, 16'h0000);
      add_request(rrss_pkg::REQ_STEP, 16'h0000, 16'h0000);

      // Random phases: most of them clear the table, load a handful of tasks
      // and step through them, with late loads and noise mixed into the steps.
      // A rare phase fills the table past its capacity.
      while (request_total < TARGET_ITEMS) begin
         if ($urandom_range(0, 9) < 3) begin
            roll = $urandom_range(0, 5);
            case (roll)
               0: q = 16'h0000;
               1: q = 16'h0001;
               2: q = 16'hFFFF;
               3: q = 16'($urandom_range(0, 65535));
               default: q = 16'($urandom_range(2, 16));
            endcase
            add_quantum_write(q);
         end
         if ($urandom_range(0, 3) != 0)
            add_request(rrss_pkg::REQ_CLEAR, 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)));
         if (full_phases < 2 && $urandom_range(0, 11) == 0) begin
            full_phases++;
            add_request(rrss_pkg::REQ_CLEAR, 16'h0000, 16'h0000);
            for (int k = 0; k < TABLE_DEPTH + 2; k++)
               add_request(rrss_pkg::REQ_LOAD, 16'($urandom_range(0, 20)),
                           16'($urandom_range(1, 3)));
            n_step = 40;
         end else begin
            n_load = $urandom_range(1, 8);
            for (int k = 0; k < n_load; k++)
               add_request(rrss_pkg::REQ_LOAD, pick_arrival(), pick_burst());
            n_step = $urandom_range(2, 3 * n_load + 6);
         end
         for (int k = 0; k < n_step; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 85)
               add_request(rrss_pkg::REQ_STEP, 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)));
            else if (roll < 90)
               add_request(rrss_pkg::REQ_LOAD, pick_arrival(), pick_burst());
            else if (roll < 94)
               add_request(REQ_RESERVED, 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)));
            else if (roll < 98)
               add_request(rrss_pkg::REQ_LOAD, 16'($urandom_range(0, 65535)), 16'h0000);
            else
               add_request(rrss_pkg::REQ_CLEAR, 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)));
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Wait until every transaction has gone in and every response is back,
      // then give the block time to show any stray response.
      while (pending_stimulus.size() != 0 || start || awaited_responses.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Driver
   // ------------------------------------------------------------------------
   // Every signal is given its next value once per edge, so start stays high
   // without a glitch when one transaction follows another directly. The
   // model is run at the edge that accepts a request, and a quantum write is
   // only issued after the block has been seen idle with nothing outstanding.
   always @(posedge clock) begin : driver
      logic                  next_start;
      logic                  next_we;
      logic [15:0]           next_wdata;
      rrss_pkg::request_type next_payload;
      stimulus_entry_type    head;
      int                    roll;
      int                    gap_left;
      int                    idle_run;
      bit                    back_to_back;
      if (reset) begin
         start    <= 1'b0;
         csr_we   <= 1'b0;
         gap_left = 0;
         idle_run = 0;
      end else begin
         next_start   = start;
         next_we      = 1'b0;
         next_wdata   = csr_wdata;
         next_payload = req_payload;

         if (awaited_responses.size() == 0 && !busy && !rsp_valid && !start && !csr_we)
            idle_run++;
         else
            idle_run = 0;

         if (start && !busy) begin
            awaited_responses.push_back(schedule_request(req_payload));
            next_start = 1'b0;
            // Now and then switch between random gaps and a stretch of
            // transactions sent back to back.
            if ($urandom_range(0, 31) == 0)
               back_to_back = !back_to_back;
            roll = $urandom_range(0, 99);
            if (back_to_back || roll < 55)
               gap_left = 0;
            else if (roll < 92)
               gap_left = $urandom_range(1, 3);
            else
               gap_left = $urandom_range(8, 40);
         end

         if (!next_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_stimulus.size() != 0) begin
               if (pending_stimulus[0].is_cfg) begin
                  if (idle_run >= 2) begin
                     head            = pending_stimulus.pop_front();
                     next_we         = 1'b1;
                     next_wdata      = head.cfg_value;
                     quantum_setting = head.cfg_value;
                     idle_run        = 0;
                  end
               end else begin
                  head         = pending_stimulus.pop_front();
                  next_start   = 1'b1;
                  next_payload = head.req;
               end
            end
         end

         start       <= next_start;
         req_payload <= next_payload;
         csr_we      <= next_we;
         csr_wdata   <= next_wdata;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor
   // ------------------------------------------------------------------------

   task automatic check_field(input string name, input logic [23:0] want,
                              input logic [23:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         failures++;
      end
   endtask

   // A response lasts one cycle and cannot be held off, so it is taken at the
   // edge that ends its cycle and compared with the oldest prediction.
   always @(posedge clock) begin : monitor
      rrss_pkg::response_type want;
      if (!reset && rsp_valid) begin
         if (awaited_responses.size() == 0) begin
            $display("%0t: response with none expected, actual status %0d",
                     $time, rsp_payload.status);
            failures++;
         end else begin
            want = awaited_responses.pop_front();
            check_field("status", 24'(want.status), 24'(rsp_payload.status));
            check_field("slice_start", want.slice_start, rsp_payload.slice_start);
            check_field("slice_end", want.slice_end, rsp_payload.slice_end);
            check_field("task_id", 24'(want.task_id), 24'(rsp_payload.task_id));
            check_field("ran", 24'(want.ran), 24'(rsp_payload.ran));
            check_field("left", 24'(want.left), 24'(rsp_payload.left));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watchdog
      int quiet_cycles;
      if (reset || (start && !busy) || rsp_valid || csr_we)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

endmodule

>>> round_robin_slice_scheduler.f
rtl/core/rrss_pkg.sv
rtl/core/rrss_cell.sv
rtl/core/rrss_ring.sv
rtl/core/round_robin_slice_scheduler.sv
tb/round_robin_slice_scheduler_tb.sv
